FILE: sv/chsd_pkg.sv
`timescale 1ns / 1ps
package chsd_pkg;

   typedef enum logic [1:0] {
      PH_HEAD,
      PH_ARG,
      PH_TEXT
   } chsd_phase_type;

   // Major types
   localparam logic [2:0] MT_UINT   = 3'd0;
   localparam logic [2:0] MT_NINT   = 3'd1;
   localparam logic [2:0] MT_BYTES  = 3'd2;
   localparam logic [2:0] MT_TEXT   = 3'd3;
   localparam logic [2:0] MT_ARRAY  = 3'd4;
   localparam logic [2:0] MT_MAP    = 3'd5;
   localparam logic [2:0] MT_TAG    = 3'd6;
   localparam logic [2:0] MT_SIMPLE = 3'd7;

   // Extra field codes
   localparam logic [4:0] EXTRA_FALSE    = 5'd20;
   localparam logic [4:0] EXTRA_TRUE     = 5'd21;
   localparam logic [4:0] EXTRA_NULL     = 5'd22;
   localparam logic [4:0] EXTRA_ONE_BYTE = 5'd24;
   localparam logic [4:0] EXTRA_RES_LO   = 5'd28;
   localparam logic [4:0] EXTRA_RES_HI   = 5'd30;
   localparam logic [4:0] EXTRA_INDEF    = 5'd31;

   // Token kinds
   localparam logic [3:0] KIND_UINT       = 4'd0;
   localparam logic [3:0] KIND_NINT       = 4'd1;
   localparam logic [3:0] KIND_TEXT_START = 4'd2;
   localparam logic [3:0] KIND_TEXT_BYTE  = 4'd3;
   localparam logic [3:0] KIND_ARRAY      = 4'd4;
   localparam logic [3:0] KIND_MAP        = 4'd5;
   localparam logic [3:0] KIND_FALSE      = 4'd6;
   localparam logic [3:0] KIND_TRUE       = 4'd7;
   localparam logic [3:0] KIND_NULL       = 4'd8;
   localparam logic [3:0] KIND_BREAK      = 4'd9;

   // Status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd1;
   localparam logic [2:0] ST_MALFORMED   = 3'd2;
   localparam logic [2:0] ST_TRUNCATED   = 3'd3;
   localparam logic [2:0] ST_OVERFLOW    = 3'd4;

   // Register byte addresses
   localparam logic [1:0] REG_SIGNED_INTS = 2'd0;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       buffer_end;
   } chsd_req_type;

   typedef struct packed {
      logic [3:0]         kind;
      logic [2:0]         head_major;
      logic [63:0]        argument;
      logic signed [63:0] signed_value;
      logic               indefinite;
      logic [7:0]         payload_byte;
      logic               string_end;
      logic [2:0]         status;
   } chsd_rsp_type;

   typedef struct packed {
      chsd_phase_type phase;
      logic [3:0]     arg_left;
      logic [63:0]    arg_accum;
      logic [2:0]     held_major;
      logic [63:0]    payload_left;
   } chsd_state_type;

endpackage

FILE: sv/chsd_csr.sv
`timescale 1ns / 1ps
module chsd_csr
   import chsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic        signed_ints
);

   logic signed_ints_ff;
   logic signed_ints_in;
   logic wr_en;

   // Only one register exists, so the address is not decoded.
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      signed_ints_in = signed_ints_ff;
      if (wr_en) begin
         signed_ints_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_ints_ff <= 1'b0;
      end else begin
         signed_ints_ff <= signed_ints_in;
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      unique case (csr_paddr)
         REG_SIGNED_INTS: csr_prdata = {31'd0, signed_ints_ff};
         default:         csr_prdata = {31'd0, signed_ints_ff};
      endcase
   end

   assign csr_pready  = 1'b1;
   assign signed_ints = signed_ints_ff;

endmodule

FILE: sv/chsd_step.sv
`timescale 1ns / 1ps
module chsd_step
   import chsd_pkg::*;
(
   input  chsd_state_type cur,
   input  chsd_req_type   word,
   input  logic           signed_ints,
   output chsd_state_type nxt,
   output logic           res_valid,
   output chsd_rsp_type   res
);

   logic [2:0]  major;
   logic [4:0]  extra;
   logic        last;
   logic [63:0] accum_new;
   logic [3:0]  left_new;
   logic        fin_en;
   logic [2:0]  fin_major;
   logic [63:0] fin_val;

   function automatic chsd_rsp_type fail_rsp(input logic [2:0] m, input logic [2:0] st);
      chsd_rsp_type r;
      r            = '0;
      r.head_major = m;
      r.status     = st;
      return r;
   endfunction

   function automatic chsd_rsp_type tok(input logic [3:0] k, input logic [2:0] m,
                                        input logic [63:0] a, input logic [63:0] sv,
                                        input logic ind, input logic [7:0] pb,
                                        input logic se);
      chsd_rsp_type r;
      r              = '0;
      r.kind         = k;
      r.head_major   = m;
      r.argument     = a;
      r.signed_value = $signed(sv);
      r.indefinite   = ind;
      r.payload_byte = pb;
      r.string_end   = se;
      r.status       = ST_OK;
      return r;
   endfunction

   assign major     = word.in_byte[7:5];
   assign extra     = word.in_byte[4:0];
   assign last      = word.buffer_end;
   assign accum_new = {cur.arg_accum[55:0], word.in_byte};
   assign left_new  = cur.arg_left - 4'd1;

   always_comb begin
      nxt       = cur;
      res_valid = 1'b0;
      res       = '0;
      fin_en    = 1'b0;
      fin_major = cur.held_major;
      fin_val   = accum_new;

      unique case (cur.phase)
         PH_ARG: begin
            nxt.arg_accum = accum_new;
            nxt.arg_left  = left_new;
            if (left_new == 4'd0) begin
               fin_en = 1'b1;
            end else if (last) begin
               res_valid = 1'b1;
               res       = fail_rsp(cur.held_major, ST_TRUNCATED);
               nxt.phase = PH_HEAD;
            end
         end
         PH_TEXT: begin
            res_valid = 1'b1;
            if (cur.payload_left <= 64'd1) begin
               nxt.payload_left = 64'd0;
               nxt.phase        = PH_HEAD;
               res = tok(KIND_TEXT_BYTE, MT_TEXT, 64'd0, 64'd0, 1'b0, word.in_byte, 1'b1);
            end else if (last) begin
               // A text byte that arrives with the buffer end is dropped.
               nxt.payload_left = 64'd0;
               nxt.phase        = PH_HEAD;
               res              = fail_rsp(MT_TEXT, ST_TRUNCATED);
            end else begin
               nxt.payload_left = cur.payload_left - 64'd1;
               res = tok(KIND_TEXT_BYTE, MT_TEXT, 64'd0, 64'd0, 1'b0, word.in_byte, 1'b0);
            end
         end
         default: begin
            nxt.held_major = major;
            nxt.phase      = PH_HEAD;
            res_valid      = 1'b1;
            if (major == MT_BYTES || major == MT_TAG || (major == MT_NINT && !signed_ints)) begin
               res = fail_rsp(major, ST_UNSUPPORTED);
            end else if (extra >= EXTRA_RES_LO && extra <= EXTRA_RES_HI) begin
               res = fail_rsp(major, ST_MALFORMED);
            end else if (major == MT_SIMPLE) begin
               case (extra)
                  EXTRA_FALSE: res = tok(KIND_FALSE, major, 64'd0, 64'd0, 1'b0, 8'd0, 1'b0);
                  EXTRA_TRUE:  res = tok(KIND_TRUE, major, 64'd0, 64'd0, 1'b0, 8'd0, 1'b0);
                  EXTRA_NULL:  res = tok(KIND_NULL, major, 64'd0, 64'd0, 1'b0, 8'd0, 1'b0);
                  EXTRA_INDEF: res = tok(KIND_BREAK, major, 64'd0, 64'd0, 1'b0, 8'd0, 1'b0);
                  default:     res = fail_rsp(major, ST_UNSUPPORTED);
               endcase
            end else if (extra == EXTRA_INDEF) begin
               case (major)
                  MT_ARRAY: res = tok(KIND_ARRAY, major, 64'd0, 64'd0, 1'b1, 8'd0, 1'b0);
                  MT_MAP:   res = tok(KIND_MAP, major, 64'd0, 64'd0, 1'b1, 8'd0, 1'b0);
                  MT_TEXT:  res = fail_rsp(major, ST_UNSUPPORTED);
                  default:  res = fail_rsp(major, ST_MALFORMED);
               endcase
            end else if (extra < EXTRA_ONE_BYTE) begin
               res_valid = 1'b0;
               fin_en    = 1'b1;
               fin_major = major;
               fin_val   = {59'd0, extra};
            end else if (last) begin
               res = fail_rsp(major, ST_TRUNCATED);
            end else begin
               // Extras 24 to 27 call for 1, 2, 4 or 8 argument bytes.
               res_valid     = 1'b0;
               nxt.arg_left  = 4'd1 << extra[1:0];
               nxt.arg_accum = 64'd0;
               nxt.phase     = PH_ARG;
            end
         end
      endcase

      if (fin_en) begin
         res_valid = 1'b1;
         nxt.phase = PH_HEAD;
         case (fin_major)
            MT_UINT: begin
               if (signed_ints && fin_val[63]) begin
                  res = fail_rsp(fin_major, ST_OVERFLOW);
               end else if (signed_ints) begin
                  res = tok(KIND_UINT, fin_major, fin_val, fin_val, 1'b0, 8'd0, 1'b0);
               end else begin
                  res = tok(KIND_UINT, fin_major, fin_val, 64'd0, 1'b0, 8'd0, 1'b0);
               end
            end
            MT_NINT: begin
               if (!signed_ints) begin
                  res = fail_rsp(fin_major, ST_UNSUPPORTED);
               end else if (fin_val[63]) begin
                  res = fail_rsp(fin_major, ST_OVERFLOW);
               end else begin
                  res = tok(KIND_NINT, fin_major, fin_val, ~fin_val, 1'b0, 8'd0, 1'b0);
               end
            end
            MT_TEXT: begin
               if (fin_val == 64'd0) begin
                  res = tok(KIND_TEXT_START, fin_major, 64'd0, 64'd0, 1'b0, 8'd0, 1'b1);
               end else if (last) begin
                  res = fail_rsp(fin_major, ST_TRUNCATED);
               end else begin
                  nxt.phase        = PH_TEXT;
                  nxt.payload_left = fin_val;
                  res = tok(KIND_TEXT_START, fin_major, fin_val, 64'd0, 1'b0, 8'd0, 1'b0);
               end
            end
            MT_ARRAY: res = tok(KIND_ARRAY, fin_major, fin_val, 64'd0, 1'b0, 8'd0, 1'b0);
            MT_MAP:   res = tok(KIND_MAP, fin_major, fin_val, 64'd0, 1'b0, 8'd0, 1'b0);
            default:  res = fail_rsp(fin_major, ST_UNSUPPORTED);
         endcase
      end
   end

endmodule

FILE: sv/cbor_head_stream_decoder_core.sv
`timescale 1ns / 1ps
// Path: a word accepted into the input register is decoded out of it into the result register
// once that register can take a token; argument bytes that complete nothing give no token.
// Throughput: one byte per cycle while the result side does not stall; a full result
// register stalls the input only when it is itself stalled.
// Reset (synchronous): clears both registers' valid bits, the decoder state and signed_ints.
module cbor_head_stream_decoder_core
   import chsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  chsd_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output chsd_rsp_type rsp_data,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic           signed_ints;
   logic           in_valid_ff, in_valid_in;
   chsd_req_type   in_data_ff, in_data_in;
   logic           rsp_valid_ff, rsp_valid_in;
   chsd_rsp_type   rsp_data_ff, rsp_data_in;
   chsd_state_type state_ff, state_in;
   chsd_state_type step_nxt;
   logic           step_valid;
   chsd_rsp_type   step_res;
   logic           out_free;
   logic           process;

   chsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .signed_ints (signed_ints)
   );

   chsd_step u_step (
      .cur         (state_ff),
      .word        (in_data_ff),
      .signed_ints (signed_ints),
      .nxt         (step_nxt),
      .res_valid   (step_valid),
      .res         (step_res)
   );

   // The held word is decoded whenever the result register can take a token.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      state_in     = state_ff;
      if (out_free) begin
         rsp_valid_in = process && step_valid;
      end
      if (process) begin
         state_in = step_nxt;
         if (step_valid) begin
            rsp_data_in = step_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         state_ff.phase        <= PH_HEAD;
         state_ff.arg_left     <= 4'd0;
         state_ff.arg_accum    <= 64'd0;
         state_ff.held_major   <= 3'd0;
         state_ff.payload_left <= 64'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_arg_left: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_ARG |-> state_ff.arg_left != 4'd0)
      else $error("argument phase with no bytes left");

   a_text_left: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_TEXT |-> state_ff.payload_left != 64'd0)
      else $error("text phase with no payload left");

   a_err_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != ST_OK |->
         rsp_data_ff.argument == 64'd0 && rsp_data_ff.kind == KIND_UINT)
      else $error("error token carries data");

   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("input stalled without a blocked result");

endmodule

FILE: sim/cbor_head_stream_decoder_core_test.sv
`timescale 1ns / 1ps
module cbor_head_stream_decoder_core_test;
   import chsd_pkg::*;

   localparam int         CYCLE_LIMIT       = 400000;
   localparam int         RANDOM_PHASES     = 6;
   localparam int         WORDS_PER_PHASE   = 155;
   localparam int         SIGNED_FROM_ROW   = 19;
   localparam int         LONG_HOLD_CYCLES  = 250;
   localparam logic [4:0] EXTRA_TWO_BYTES   = EXTRA_ONE_BYTE + 5'd1;
   localparam logic [4:0] EXTRA_EIGHT_BYTES = EXTRA_ONE_BYTE + 5'd3;

   typedef struct packed {
      chsd_req_type word;
      logic         typed;
      chsd_rsp_type tok;
   } probe_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   chsd_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   chsd_rsp_type rsp_data;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [1:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // Decoder state as the block should hold it.
   chsd_phase_type dec_phase = PH_HEAD;
   logic [3:0]     dec_arg_left = '0;
   logic [63:0]    dec_accum = '0;
   logic [2:0]     dec_major = '0;
   logic [63:0]    dec_text_left = '0;
   logic           mode_signed = 1'b0;

   chsd_rsp_type  expected_tokens[$];
   chsd_req_type  stream_words[$];
   probe_row_type probe_rows[$];
   int            mismatches = 0;
   int            cycle_count = 0;
   bit            hold_request = 1'b0;

   cbor_head_stream_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   function automatic chsd_rsp_type make_token(input logic [3:0] kind, input logic [2:0] major,
                                               input logic [63:0] arg, input logic [63:0] sval,
                                               input logic indef, input logic [7:0] pbyte,
                                               input logic send, input logic [2:0] st);
      chsd_rsp_type t;
      t.kind         = kind;
      t.head_major   = major;
      t.argument     = arg;
      t.signed_value = sval;
      t.indefinite   = indef;
      t.payload_byte = pbyte;
      t.string_end   = send;
      t.status       = st;
      return t;
   endfunction

   function automatic chsd_rsp_type error_token(input logic [2:0] major, input logic [2:0] st);
      return make_token(KIND_UINT, major, '0, '0, 1'b0, 8'd0, 1'b0, st);
   endfunction

   // Token for a head whose argument is complete; the mode is taken at this point.
   function automatic chsd_rsp_type finish_arg(input logic [2:0] major, input logic [63:0] val,
                                               input logic last);
      dec_phase = PH_HEAD;
      case (major)
         MT_UINT: begin
            if (mode_signed && val[63])
               return error_token(major, ST_OVERFLOW);
            return make_token(KIND_UINT, major, val, mode_signed ? val : 64'd0,
                              1'b0, 8'd0, 1'b0, ST_OK);
         end
         MT_NINT: begin
            if (!mode_signed)
               return error_token(major, ST_UNSUPPORTED);
            if (val[63])
               return error_token(major, ST_OVERFLOW);
            return make_token(KIND_NINT, major, val, ~val, 1'b0, 8'd0, 1'b0, ST_OK);
         end
         MT_TEXT: begin
            if (val == 64'd0)
               return make_token(KIND_TEXT_START, major, '0, '0, 1'b0, 8'd0, 1'b1, ST_OK);
            if (last)
               return error_token(major, ST_TRUNCATED);
            dec_phase = PH_TEXT;
            dec_text_left = val;
            return make_token(KIND_TEXT_START, major, val, '0, 1'b0, 8'd0, 1'b0, ST_OK);
         end
         MT_ARRAY: return make_token(KIND_ARRAY, major, val, '0, 1'b0, 8'd0, 1'b0, ST_OK);
         MT_MAP:   return make_token(KIND_MAP, major, val, '0, 1'b0, 8'd0, 1'b0, ST_OK);
         default:  return error_token(major, ST_UNSUPPORTED);
      endcase
   endfunction

   function automatic bit decode_word(input chsd_req_type w, output chsd_rsp_type tok);
      logic [2:0] major;
      logic [4:0] extra;
      major = w.in_byte[7:5];
      extra = w.in_byte[4:0];
      tok = '0;
      case (dec_phase)
         PH_ARG: begin
            dec_accum = {dec_accum[55:0], w.in_byte};
            if (dec_arg_left != 4'd0)
               dec_arg_left--;
            if (dec_arg_left == 4'd0) begin
               tok = finish_arg(dec_major, dec_accum, w.buffer_end);
               return 1'b1;
            end
            if (w.buffer_end) begin
               dec_phase = PH_HEAD;
               tok = error_token(dec_major, ST_TRUNCATED);
               return 1'b1;
            end
            return 1'b0;
         end
         PH_TEXT: begin
            if (dec_text_left <= 64'd1) begin
               dec_text_left = '0;
               dec_phase = PH_HEAD;
               tok = make_token(KIND_TEXT_BYTE, MT_TEXT, '0, '0, 1'b0, w.in_byte, 1'b1, ST_OK);
               return 1'b1;
            end
            if (w.buffer_end) begin
               dec_text_left = '0;
               dec_phase = PH_HEAD;
               tok = error_token(MT_TEXT, ST_TRUNCATED);
               return 1'b1;
            end
            dec_text_left--;
            tok = make_token(KIND_TEXT_BYTE, MT_TEXT, '0, '0, 1'b0, w.in_byte, 1'b0, ST_OK);
            return 1'b1;
         end
         default: begin
            dec_major = major;
            if (major == MT_BYTES || major == MT_TAG || (major == MT_NINT && !mode_signed)) begin
               tok = error_token(major, ST_UNSUPPORTED);
            end else if (extra >= EXTRA_RES_LO && extra <= EXTRA_RES_HI) begin
               tok = error_token(major, ST_MALFORMED);
            end else if (major == MT_SIMPLE) begin
               case (extra)
                  EXTRA_FALSE: tok = make_token(KIND_FALSE, major, '0, '0, 1'b0, 8'd0, 1'b0, ST_OK);
                  EXTRA_TRUE:  tok = make_token(KIND_TRUE, major, '0, '0, 1'b0, 8'd0, 1'b0, ST_OK);
                  EXTRA_NULL:  tok = make_token(KIND_NULL, major, '0, '0, 1'b0, 8'd0, 1'b0, ST_OK);
                  EXTRA_INDEF: tok = make_token(KIND_BREAK, major, '0, '0, 1'b0, 8'd0, 1'b0, ST_OK);
                  default:     tok = error_token(major, ST_UNSUPPORTED);
               endcase
            end else if (extra == EXTRA_INDEF) begin
               if (major == MT_ARRAY)
                  tok = make_token(KIND_ARRAY, major, '0, '0, 1'b1, 8'd0, 1'b0, ST_OK);
               else if (major == MT_MAP)
                  tok = make_token(KIND_MAP, major, '0, '0, 1'b1, 8'd0, 1'b0, ST_OK);
               else if (major == MT_TEXT)
                  tok = error_token(major, ST_UNSUPPORTED);
               else
                  tok = error_token(major, ST_MALFORMED);
            end else if (extra < EXTRA_ONE_BYTE) begin
               tok = finish_arg(major, {59'd0, extra}, w.buffer_end);
            end else if (w.buffer_end) begin
               tok = error_token(major, ST_TRUNCATED);
            end else begin
               dec_arg_left = 4'd1 << (extra - EXTRA_ONE_BYTE);
               dec_accum = '0;
               dec_phase = PH_ARG;
               return 1'b0;
            end
            return 1'b1;
         end
      endcase
   endfunction

   function automatic probe_row_type probe(input logic [7:0] b, input logic last);
      probe_row_type r;
      r.word.in_byte = b;
      r.word.buffer_end = last;
      r.typed = 1'b0;
      r.tok = '0;
      return r;
   endfunction

   function automatic probe_row_type probe_typed(input logic [7:0] b, input logic last,
                                                 input chsd_rsp_type tok);
      probe_row_type r;
      r = probe(b, last);
      r.typed = 1'b1;
      r.tok = tok;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : token_check
      chsd_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: token mismatch, expected none, actual %h", $time, rsp_data);
            mismatches++;
         end else begin
            want = expected_tokens.pop_front();
            check_field("kind", 64'(want.kind), 64'(rsp_data.kind));
            check_field("head_major", 64'(want.head_major), 64'(rsp_data.head_major));
            check_field("argument", want.argument, rsp_data.argument);
            check_field("signed_value", want.signed_value, rsp_data.signed_value);
            check_field("indefinite", 64'(want.indefinite), 64'(rsp_data.indefinite));
            check_field("payload_byte", 64'(want.payload_byte), 64'(rsp_data.payload_byte));
            check_field("string_end", 64'(want.string_end), 64'(rsp_data.string_end));
            check_field("status", 64'(want.status), 64'(rsp_data.status));
         end
      end
   end

   // Result side: stall patterns that change every so often, plus one long hold on request.
   initial begin : rsp_pacing
      int   pace;
      int   span;
      int   hold_left;
      int   tick;
      logic stall_next;
      pace = 0;
      span = 0;
      hold_left = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_request && hold_left == 0) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (span == 0) begin
            pace = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
         end
         span--;
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            case (pace)
               0:       stall_next = 1'b0;
               1:       stall_next = ($urandom_range(0, 3) == 0);
               2:       stall_next = ($urandom_range(0, 3) != 0);
               default: stall_next = ((tick % 5) < 2);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic offer_word(input chsd_req_type w, input logic typed, input chsd_rsp_type lit);
      chsd_rsp_type tok;
      bit           made;
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      made = decode_word(w, tok);
      if (typed)
         expected_tokens.push_back(lit);
      else if (made)
         expected_tokens.push_back(tok);
      @(negedge clock);
   endtask

   task automatic drain();
      while (expected_tokens.size() != 0)
         @(negedge clock);
      // A trailing argument word may still be in the pipeline without a token.
      repeat (4) @(negedge clock);
   endtask

   task automatic write_mode(input logic value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= REG_SIGNED_INTS;
      csr_pwdata <= {31'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      mode_signed = value;
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {31'd0, value}) begin
         $display("%0t: signed_ints readback mismatch, expected %0h, actual %0h",
                  $time, {31'd0, value}, csr_prdata);
         mismatches++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic queue_word(input logic [7:0] b);
      chsd_req_type w;
      w.in_byte = b;
      w.buffer_end = ($urandom_range(0, 99) < 2);
      stream_words.push_back(w);
   endtask

   // Integer or container head with an immediate or 1/2/4/8-byte argument.
   task automatic queue_argument(input logic [2:0] major);
      int         width;
      int         style;
      logic [4:0] extra;
      logic [7:0] b;
      if ($urandom_range(0, 2) == 0) begin
         extra = 5'($urandom_range(0, 23));
         queue_word({major, extra});
      end else begin
         width = $urandom_range(0, 3);
         style = $urandom_range(0, 3);
         extra = EXTRA_ONE_BYTE + 5'(width);
         queue_word({major, extra});
         for (int k = 0; k < (1 << width); k++) begin
            case (style)
               0:       b = 8'($urandom);
               1:       b = 8'hff;
               2:       b = (k == 0) ? 8'h7f : 8'hff;
               default: b = (k == 0) ? 8'h80 : 8'h00;
            endcase
            queue_word(b);
         end
      end
   endtask

   task automatic queue_sequence();
      int           first;
      int           pick;
      int           len;
      int           width;
      int           idx;
      logic [2:0]   major;
      logic [4:0]   extra;
      logic [7:0]   b;
      chsd_req_type w;
      first = stream_words.size();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         queue_argument($urandom_range(0, 1) ? MT_NINT : MT_UINT);
      end else if (pick < 55) begin
         len = $urandom_range(0, 8);
         if ($urandom_range(0, 1)) begin
            extra = 5'(len);
            queue_word({MT_TEXT, extra});
         end else begin
            // Non-minimal length encodings are legal and get the same tokens.
            width = $urandom_range(0, 3);
            extra = EXTRA_ONE_BYTE + 5'(width);
            queue_word({MT_TEXT, extra});
            for (int k = (1 << width) - 1; k >= 0; k--) begin
               b = (k == 0) ? 8'(len) : 8'd0;
               queue_word(b);
            end
         end
         for (int k = 0; k < len; k++) begin
            b = 8'($urandom);
            queue_word(b);
         end
      end else if (pick < 70) begin
         major = $urandom_range(0, 1) ? MT_MAP : MT_ARRAY;
         if ($urandom_range(0, 3) == 0)
            queue_word({major, EXTRA_INDEF});
         else
            queue_argument(major);
      end else if (pick < 84) begin
         case ($urandom_range(0, 4))
            0:       extra = EXTRA_FALSE;
            1:       extra = EXTRA_TRUE;
            2:       extra = EXTRA_NULL;
            3:       extra = EXTRA_INDEF;
            default: extra = 5'($urandom);
         endcase
         queue_word({MT_SIMPLE, extra});
      end else begin
         b = 8'($urandom);
         queue_word(b);
      end
      if ($urandom_range(0, 9) == 0) begin
         // Cut the sequence short with an early end of buffer.
         idx = $urandom_range(first, stream_words.size() - 1);
         w = stream_words[idx];
         w.buffer_end = 1'b1;
         stream_words[idx] = w;
      end else if ($urandom_range(0, 11) == 0) begin
         w = stream_words.pop_back();
         w.buffer_end = 1'b1;
         stream_words.push_back(w);
      end
   endtask

   task automatic send_words(input int count);
      int burst;
      burst = $urandom_range(1, 12);
      repeat (count) begin
         if (stream_words.size() == 0)
            queue_sequence();
         offer_word(stream_words.pop_front(), 1'b0, '0);
         burst--;
         if (burst == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      logic phase_modes [RANDOM_PHASES];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      phase_modes = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

      // Unsigned mode, as after reset.
      probe_rows.push_back(probe_typed({MT_UINT, 5'd0}, 1'b0,
         make_token(KIND_UINT, MT_UINT, '0, '0, 1'b0, 8'd0, 1'b0, ST_OK)));
      probe_rows.push_back(probe_typed({MT_NINT, 5'd0}, 1'b0,
         error_token(MT_NINT, ST_UNSUPPORTED)));
      probe_rows.push_back(probe_typed({MT_BYTES, 5'd0}, 1'b0,
         error_token(MT_BYTES, ST_UNSUPPORTED)));
      probe_rows.push_back(probe_typed({MT_TAG, 5'd0}, 1'b0,
         error_token(MT_TAG, ST_UNSUPPORTED)));
      probe_rows.push_back(probe_typed({MT_UINT, EXTRA_RES_LO}, 1'b0,
         error_token(MT_UINT, ST_MALFORMED)));
      probe_rows.push_back(probe_typed({MT_UINT, EXTRA_INDEF}, 1'b0,
         error_token(MT_UINT, ST_MALFORMED)));
      probe_rows.push_back(probe_typed({MT_TEXT, EXTRA_INDEF}, 1'b0,
         error_token(MT_TEXT, ST_UNSUPPORTED)));
      probe_rows.push_back(probe_typed({MT_SIMPLE, EXTRA_FALSE}, 1'b0,
         make_token(KIND_FALSE, MT_SIMPLE, '0, '0, 1'b0, 8'd0, 1'b0, ST_OK)));
      probe_rows.push_back(probe_typed({MT_SIMPLE, EXTRA_TRUE}, 1'b0,
         make_token(KIND_TRUE, MT_SIMPLE, '0, '0, 1'b0, 8'd0, 1'b0, ST_OK)));
      probe_rows.push_back(probe_typed({MT_SIMPLE, EXTRA_NULL}, 1'b0,
         make_token(KIND_NULL, MT_SIMPLE, '0, '0, 1'b0, 8'd0, 1'b0, ST_OK)));
      probe_rows.push_back(probe_typed({MT_SIMPLE, EXTRA_INDEF}, 1'b0,
         make_token(KIND_BREAK, MT_SIMPLE, '0, '0, 1'b0, 8'd0, 1'b0, ST_OK)));
      probe_rows.push_back(probe_typed({MT_SIMPLE, EXTRA_TWO_BYTES}, 1'b0,
         error_token(MT_SIMPLE, ST_UNSUPPORTED)));
      probe_rows.push_back(probe_typed({MT_ARRAY, EXTRA_INDEF}, 1'b0,
         make_token(KIND_ARRAY, MT_ARRAY, '0, '0, 1'b1, 8'd0, 1'b0, ST_OK)));
      probe_rows.push_back(probe_typed({MT_MAP, EXTRA_INDEF}, 1'b0,
         make_token(KIND_MAP, MT_MAP, '0, '0, 1'b1, 8'd0, 1'b0, ST_OK)));
      probe_rows.push_back(probe_typed({MT_TEXT, 5'd0}, 1'b0,
         make_token(KIND_TEXT_START, MT_TEXT, '0, '0, 1'b0, 8'd0, 1'b1, ST_OK)));
      probe_rows.push_back(probe_typed({MT_UINT, EXTRA_TWO_BYTES}, 1'b1,
         error_token(MT_UINT, ST_TRUNCATED)));
      probe_rows.push_back(probe({MT_TEXT, 5'd2}, 1'b0));
      probe_rows.push_back(probe(8'h41, 1'b0));
      probe_rows.push_back(probe(8'h42, 1'b0));
      // Signed mode: the largest unsigned argument overflows.
      probe_rows.push_back(probe({MT_UINT, EXTRA_EIGHT_BYTES}, 1'b0));
      repeat (7) probe_rows.push_back(probe(8'hff, 1'b0));
      probe_rows.push_back(probe_typed(8'hff, 1'b0, error_token(MT_UINT, ST_OVERFLOW)));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (probe_rows[i]) begin
         if (i == SIGNED_FROM_ROW) begin
            req_valid <= 1'b0;
            drain();
            write_mode(1'b1);
         end
         offer_word(probe_rows[i].word, probe_rows[i].typed, probe_rows[i].tok);
      end
      req_valid <= 1'b0;
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_mode(phase_modes[p]);
         // The receiver holds off while words keep coming, so the block backs up.
         if (p == 2)
            hold_request = 1'b1;
         send_words(WORDS_PER_PHASE);
         drain();
      end

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
